@@ rtl/unixdt_pkg.sv @@
// unixdt_pkg: types and constants shared by the unix time to rtc date/time block
// no dependencies; imported by the controller, datapath and top level

package unixdt_pkg;

    // which calendar unit the walk takes off the remaining time
    typedef enum logic [2:0] {
        UNIT_YEAR  = 3'd0,
        UNIT_MONTH = 3'd1,
        UNIT_DAY   = 3'd2,
        UNIT_HOUR  = 3'd3,
        UNIT_MIN10 = 3'd4,   // ten minutes
        UNIT_MIN   = 3'd5,
        UNIT_SEC10 = 3'd6,   // ten seconds
        UNIT_SEC   = 3'd7
    } unit_t;

    typedef struct packed {
        logic  load;
        logic  step;
        logic  advance;
        unit_t unit;
        logic  finish;
    } unixdt_cmd_t;

    typedef struct packed {
        logic fits;
        logic in_range;
    } unixdt_sts_t;

    localparam logic [63:0] NS_PER_SEC   = 64'd1000000000;
    localparam logic [63:0] NS_PER_10SEC = 64'd10 * NS_PER_SEC;
    localparam logic [63:0] NS_PER_MIN   = 64'd60 * NS_PER_SEC;
    localparam logic [63:0] NS_PER_10MIN = 64'd600 * NS_PER_SEC;
    localparam logic [63:0] NS_PER_HOUR  = 64'd3600 * NS_PER_SEC;
    localparam logic [63:0] NS_PER_DAY   = 64'd86400 * NS_PER_SEC;
    localparam logic [63:0] NS_PER_28D   = 64'd28 * NS_PER_DAY;
    localparam logic [63:0] NS_PER_29D   = 64'd29 * NS_PER_DAY;
    localparam logic [63:0] NS_PER_30D   = 64'd30 * NS_PER_DAY;
    localparam logic [63:0] NS_PER_31D   = 64'd31 * NS_PER_DAY;
    localparam logic [63:0] NS_PER_365D  = 64'd365 * NS_PER_DAY;
    localparam logic [63:0] NS_PER_366D  = 64'd366 * NS_PER_DAY;

    localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
    localparam logic [11:0] FIRST_YEAR   = 12'd2000;
    localparam logic [11:0] LAST_YEAR    = 12'd2099;
    localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
    localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
    localparam logic [2:0]  EPOCH_WDAY   = 3'd3;    // thursday, counted from monday as 0

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

endpackage

@@ rtl/unix_ns_to_rtc_date_time.sv @@
// unix_ns_to_rtc_date_time: top level of the unix time to rtc calendar converter
// depends on unixdt_pkg, unixdt_ctrl and unixdt_dp

// Converts nanoseconds since 1970-01-01 00:00:00 UTC into rtc calendar fields.
// A transfer in is taken on a clock edge with start high and busy low; busy then
// stays high until the conversion is finished. The result is shown for exactly
// one cycle with done high and cannot be held off, so the receiver must take it
// in that cycle. The datapath takes whole calendar units off the remaining time,
// one compare and subtract per cycle: up to 129 years from 1970 (130 when the
// time runs past 2099), 11 months, 30 days, 23 hours, then minutes and seconds
// in tens and ones (14 steps each); each walk ends with a step that moves on to
// the next unit or to the finish state, which loads the result. Busy time is set
// mostly by the one-year-per-cycle walk, and the next transfer may start in the
// cycle that shows done. Years outside 2000 to 2099 end after the year walk with
// in_range low and every other field zero; the sub-second part is truncated.

module unix_ns_to_rtc_date_time
    import unixdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] time_ns,
    output logic        busy,
    output logic        done,
    output logic        in_range,
    output logic [6:0]  year_of_century,
    output logic [3:0]  month_number,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hours,
    output logic [5:0]  minutes,
    output logic [5:0]  seconds,
    output logic [2:0]  week_day
);

    // command and status between sequencer and datapath
    unixdt_cmd_t cmd;
    unixdt_sts_t sts;

    unixdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // calendar walk and result registers
    unixdt_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .time_ns         (time_ns),
        .cmd             (cmd),
        .sts             (sts),
        .done            (done),
        .in_range        (in_range),
        .year_of_century (year_of_century),
        .month_number    (month_number),
        .day_of_month    (day_of_month),
        .hours           (hours),
        .minutes         (minutes),
        .seconds         (seconds),
        .week_day        (week_day)
    );

endmodule

@@ rtl/unixdt_ctrl.sv @@
// unixdt_ctrl: sequencer for the date/time conversion
// depends on unixdt_pkg; drives the datapath through unixdt_cmd_t

module unixdt_ctrl
    import unixdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  unixdt_sts_t sts,
    output unixdt_cmd_t cmd,
    output logic        busy
);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_YEAR  = 10'b0000000010,
        ST_MONTH = 10'b0000000100,
        ST_DAY   = 10'b0000001000,
        ST_HOUR  = 10'b0000010000,
        ST_MIN10 = 10'b0000100000,
        ST_MIN   = 10'b0001000000,
        ST_SEC10 = 10'b0010000000,
        ST_SEC   = 10'b0100000000,
        ST_FIN   = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.advance = 1'b0;
        cmd.unit    = UNIT_YEAR;
        cmd.finish  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    cmd.unit   = UNIT_YEAR;
                    state_next = ST_YEAR;
                end
            end
            ST_YEAR:
            begin
                if (sts.fits)
                    cmd.step = 1'b1;
                else if (sts.in_range)
                begin
                    cmd.advance = 1'b1;
                    cmd.unit    = UNIT_MONTH;
                    state_next  = ST_MONTH;
                end
                else
                    state_next = ST_FIN;
            end
            ST_MONTH:
            begin
                if (sts.fits)
                    cmd.step = 1'b1;
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.unit    = UNIT_DAY;
                    state_next  = ST_DAY;
                end
            end
            ST_DAY:
            begin
                if (sts.fits)
                    cmd.step = 1'b1;
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.unit    = UNIT_HOUR;
                    state_next  = ST_HOUR;
                end
            end
            ST_HOUR:
            begin
                if (sts.fits)
                    cmd.step = 1'b1;
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.unit    = UNIT_MIN10;
                    state_next  = ST_MIN10;
                end
            end
            ST_MIN10:
            begin
                if (sts.fits)
                    cmd.step = 1'b1;
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.unit    = UNIT_MIN;
                    state_next  = ST_MIN;
                end
            end
            ST_MIN:
            begin
                if (sts.fits)
                    cmd.step = 1'b1;
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.unit    = UNIT_SEC10;
                    state_next  = ST_SEC10;
                end
            end
            ST_SEC10:
            begin
                if (sts.fits)
                    cmd.step = 1'b1;
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.unit    = UNIT_SEC;
                    state_next  = ST_SEC;
                end
            end
            ST_SEC:
            begin
                if (sts.fits)
                    cmd.step = 1'b1;
                else
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

@@ rtl/unixdt_dp.sv @@
// unixdt_dp: calendar walk by compare and subtract on the nanosecond time, and result registers
// depends on unixdt_pkg; controlled by unixdt_ctrl

module unixdt_dp
    import unixdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [63:0] time_ns,
    input  unixdt_cmd_t cmd,
    output unixdt_sts_t sts,
    output logic        done,
    output logic        in_range,
    output logic [6:0]  year_of_century,
    output logic [3:0]  month_number,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hours,
    output logic [5:0]  minutes,
    output logic [5:0]  seconds,
    output logic [2:0]  week_day
);

    // remaining time and the calendar counters it has been walked into
    logic [63:0] rem_reg;
    unit_t       unit_reg;
    logic [11:0] year_reg;
    logic [6:0]  c100_reg;
    logic [8:0]  c400_reg;
    logic [3:0]  month_reg;
    logic [4:0]  day_reg;      // whole days walked into the month
    logic [4:0]  hr_reg;
    logic [5:0]  min_reg;
    logic [5:0]  sec_reg;
    logic [2:0]  wday_reg;     // weekday, monday as 0

    // result registers
    logic        done_reg;
    logic        rng_reg;
    logic [6:0]  yoc_reg;
    logic [3:0]  mon_reg;
    logic [4:0]  dom_reg;
    logic [4:0]  hrs_reg;
    logic [5:0]  mins_reg;
    logic [5:0]  secs_out_reg;
    logic [2:0]  wd_reg;

    logic        leap;
    logic [3:0]  month_idx;
    logic [4:0]  month_days;
    logic [63:0] month_ns;
    logic [63:0] unit_ns;
    logic        limit_ok;
    logic [2:0]  wday_inc;
    logic [3:0]  wday_sum;
    logic [3:0]  wday_wrap;
    logic [2:0]  wday_next;
    logic        year_ok;
    logic [11:0] year_ofs;

    // gregorian rule from running residues of the year
    assign leap       = (year_reg[1:0] == 2'd0) && ((c100_reg != 7'd0) || (c400_reg == 9'd0));
    assign month_idx  = month_reg - 4'd1;
    assign month_days = MONTH_LEN[month_idx] + {4'd0, (month_reg == 4'd2) && leap};
    assign year_ok    = (year_reg >= FIRST_YEAR) && (year_reg <= LAST_YEAR);
    assign year_ofs   = year_reg - FIRST_YEAR;

    always_comb
    begin
        case (month_days)
            5'd28:   month_ns = NS_PER_28D;
            5'd29:   month_ns = NS_PER_29D;
            5'd30:   month_ns = NS_PER_30D;
            default: month_ns = NS_PER_31D;
        endcase
    end

    // length of the unit being walked, and the loop bound of the year and month walks
    always_comb
    begin
        limit_ok = 1'b1;
        case (unit_reg)
            UNIT_YEAR:
            begin
                unit_ns  = leap ? NS_PER_366D : NS_PER_365D;
                limit_ok = (year_reg <= LAST_YEAR);
            end
            UNIT_MONTH:
            begin
                unit_ns  = month_ns;
                limit_ok = (month_reg < 4'd12);
            end
            UNIT_DAY:   unit_ns = NS_PER_DAY;
            UNIT_HOUR:  unit_ns = NS_PER_HOUR;
            UNIT_MIN10: unit_ns = NS_PER_10MIN;
            UNIT_MIN:   unit_ns = NS_PER_MIN;
            UNIT_SEC10: unit_ns = NS_PER_10SEC;
            UNIT_SEC:   unit_ns = NS_PER_SEC;
            default:    unit_ns = NS_PER_SEC;
        endcase
    end

    // weekday moves by the day count mod 7; 28 is a multiple of 7 and of 4
    always_comb
    begin
        case (unit_reg)
            UNIT_YEAR:  wday_inc = leap ? 3'd2 : 3'd1;
            UNIT_MONTH: wday_inc = {1'b0, month_days[1:0]};
            default:    wday_inc = 3'd1;
        endcase
    end

    assign wday_sum  = {1'b0, wday_reg} + {1'b0, wday_inc};
    assign wday_wrap = wday_sum - 4'd7;
    assign wday_next = (wday_sum >= 4'd7) ? wday_wrap[2:0] : wday_sum[2:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg   <= time_ns;
            unit_reg  <= cmd.unit;
            year_reg  <= EPOCH_YEAR;
            c100_reg  <= EPOCH_MOD100;
            c400_reg  <= EPOCH_MOD400;
            month_reg <= 4'd1;
            day_reg   <= 5'd0;
            hr_reg    <= 5'd0;
            min_reg   <= 6'd0;
            sec_reg   <= 6'd0;
            wday_reg  <= EPOCH_WDAY;
        end
        else if (cmd.advance)
        begin
            unit_reg <= cmd.unit;
        end
        else if (cmd.step)
        begin
            rem_reg <= rem_reg - unit_ns;
            case (unit_reg)
                UNIT_YEAR:
                begin
                    year_reg <= year_reg + 12'd1;
                    c100_reg <= (c100_reg == 7'd99) ? 7'd0 : c100_reg + 7'd1;
                    c400_reg <= (c400_reg == 9'd399) ? 9'd0 : c400_reg + 9'd1;
                    wday_reg <= wday_next;
                end
                UNIT_MONTH:
                begin
                    month_reg <= month_reg + 4'd1;
                    wday_reg  <= wday_next;
                end
                UNIT_DAY:
                begin
                    day_reg  <= day_reg + 5'd1;
                    wday_reg <= wday_next;
                end
                UNIT_HOUR:  hr_reg  <= hr_reg + 5'd1;
                UNIT_MIN10: min_reg <= min_reg + 6'd10;
                UNIT_MIN:   min_reg <= min_reg + 6'd1;
                UNIT_SEC10: sec_reg <= sec_reg + 6'd10;
                UNIT_SEC:   sec_reg <= sec_reg + 6'd1;
                default:    sec_reg <= sec_reg + 6'd1;
            endcase
        end
    end

    assign sts.fits     = limit_ok && (rem_reg >= unit_ns);
    assign sts.in_range = year_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= cmd.finish;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            rng_reg      <= year_ok;
            yoc_reg      <= year_ok ? year_ofs[6:0] : 7'd0;
            mon_reg      <= year_ok ? month_reg : 4'd0;
            dom_reg      <= year_ok ? day_reg + 5'd1 : 5'd0;
            hrs_reg      <= year_ok ? hr_reg : 5'd0;
            mins_reg     <= year_ok ? min_reg : 6'd0;
            secs_out_reg <= year_ok ? sec_reg : 6'd0;
            wd_reg       <= year_ok ? wday_reg + 3'd1 : 3'd0;
        end
    end

    assign done            = done_reg;
    assign in_range        = rng_reg;
    assign year_of_century = yoc_reg;
    assign month_number    = mon_reg;
    assign day_of_month    = dom_reg;
    assign hours           = hrs_reg;
    assign minutes         = mins_reg;
    assign seconds         = secs_out_reg;
    assign week_day        = wd_reg;

endmodule

@@ rtl/unixdt_chk.sv @@
// unixdt_chk: port-level checks for unix_ns_to_rtc_date_time
// no package dependency; bound to the top level below

module unixdt_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic [63:0] time_ns,
    input logic        busy,
    input logic        done,
    input logic        in_range,
    input logic [6:0]  year_of_century,
    input logic [3:0]  month_number,
    input logic [4:0]  day_of_month,
    input logic [4:0]  hours,
    input logic [5:0]  minutes,
    input logic [5:0]  seconds,
    input logic [2:0]  week_day
);

    // accepted transfer makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted transfer");

    // a result only follows a busy period
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("done without a conversion in flight");

    // out of range results are all zero
    a_zero_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !in_range |-> (year_of_century == 7'd0) && (month_number == 4'd0) &&
            (day_of_month == 5'd0) && (hours == 5'd0) && (minutes == 6'd0) &&
            (seconds == 6'd0) && (week_day == 3'd0))
        else $error("nonzero fields on out of range result");

    // in range results are legal calendar values
    a_fields_legal: assert property (@(posedge clk) disable iff (!rst_n)
        done && in_range |-> (year_of_century <= 7'd99) && (month_number >= 4'd1) &&
            (month_number <= 4'd12) && (day_of_month >= 5'd1) && (hours <= 5'd23) &&
            (minutes <= 6'd59) && (seconds <= 6'd59) && (week_day >= 3'd1))
        else $error("illegal calendar field on result");

endmodule

bind unix_ns_to_rtc_date_time unixdt_chk u_chk (.*);

@@ dv/tb_unix_ns_to_rtc_date_time.sv @@
`timescale 1ns / 1ps
// tb_unix_ns_to_rtc_date_time: self-checking bench for the unix time to rtc calendar block
// depends only on the rtl top level unix_ns_to_rtc_date_time and what it pulls in
// directed table first, then random times, checked against typed expectations or a calendar predictor

module tb_unix_ns_to_rtc_date_time;

    // one result as the rtc sees it, in port order
    typedef struct packed {
        logic       in_range;
        logic [6:0] year_of_century;
        logic [3:0] month_number;
        logic [4:0] day_of_month;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        logic [2:0] week_day;
    } rtc_fields_t;

    localparam logic [63:0] NS_PER_S     = 64'd1000000000;
    localparam logic [63:0] SEC_PER_DAY  = 64'd86400;
    localparam int unsigned YEAR_ORIGIN  = 1970;
    localparam int unsigned YEAR_LO      = 2000;
    localparam int unsigned YEAR_HI      = 2099;
    localparam int unsigned RANDOM_TIMES = 650;
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned LIMIT_CYCLES = 1000000;  // about 6x the slowest correct run
    localparam rtc_fields_t NO_DATE      = '0;       // out of range: every field zero

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [63:0] time_ns;
    logic        busy;
    logic        done;
    logic        in_range;
    logic [6:0]  year_of_century;
    logic [3:0]  month_number;
    logic [4:0]  day_of_month;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [2:0]  week_day;

    rtc_fields_t calendar_due[$];   // expected dates, oldest first
    rtc_fields_t pending_cal;       // expectation for the time on the input ports
    int unsigned mismatches;
    int unsigned cycles;
    bit          idle_on;           // sender may drop start at random

    // directed table: a time, and a typed expectation where one is given
    logic [63:0] row_time[$];
    bit          row_typed[$];
    rtc_fields_t row_want[$];

    unix_ns_to_rtc_date_time uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .time_ns         (time_ns),
        .busy            (busy),
        .done            (done),
        .in_range        (in_range),
        .year_of_century (year_of_century),
        .month_number    (month_number),
        .day_of_month    (day_of_month),
        .hours           (hours),
        .minutes         (minutes),
        .seconds         (seconds),
        .week_day        (week_day)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // gregorian rule: every fourth year, but centuries only every fourth one
    function automatic bit is_leap(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned year_len(input int unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    function automatic int unsigned mdays(input int unsigned y, input int unsigned mo);
        case (mo)
            2:             return is_leap(y) ? 29 : 28;
            4, 6, 9, 11:   return 30;
            default:       return 31;
        endcase
    endfunction

    // nanosecond time of a calendar date, used to aim stimulus at dates
    function automatic logic [63:0] stamp(input int unsigned y, input int unsigned mo,
                                          input int unsigned d, input int unsigned hh,
                                          input int unsigned mi, input int unsigned ss,
                                          input int unsigned ns);
        logic [63:0] acc;
        acc = 64'(d - 1);
        for (int unsigned yy = YEAR_ORIGIN; yy < y; yy++)
            acc += year_len(yy);
        for (int unsigned mm = 1; mm < mo; mm++)
            acc += mdays(y, mm);
        acc = acc * SEC_PER_DAY + 64'(hh * 3600 + mi * 60 + ss);
        return acc * NS_PER_S + 64'(ns);
    endfunction

    // predictor: walk years from the origin, then months, then split the day
    function automatic rtc_fields_t to_calendar(input logic [63:0] t);
        logic [63:0] secs;
        logic [63:0] days;
        logic [63:0] rest;
        logic [31:0] sod;
        int unsigned yr;
        int unsigned mo;
        rtc_fields_t r;
        secs = t / NS_PER_S;            // sub-second part truncated
        days = secs / SEC_PER_DAY;
        sod  = 32'(secs % SEC_PER_DAY);
        rest = days;
        yr   = YEAR_ORIGIN;
        mo   = 1;
        r    = NO_DATE;
        // the walk stops past the last accepted year, so huge inputs stay cheap
        while (yr <= YEAR_HI && rest >= 64'(year_len(yr)))
        begin
            rest -= 64'(year_len(yr));
            yr++;
        end
        if (yr >= YEAR_LO && yr <= YEAR_HI)
        begin
            while (mo < 12 && rest >= 64'(mdays(yr, mo)))
            begin
                rest -= 64'(mdays(yr, mo));
                mo++;
            end
            r.in_range        = 1'b1;
            r.year_of_century = 7'(yr - YEAR_LO);
            r.month_number    = 4'(mo);
            r.day_of_month    = 5'(rest + 64'd1);
            r.hours           = 5'(sod / 3600);
            r.minutes         = 6'((sod % 3600) / 60);
            r.seconds         = 6'(sod % 60);
            // the origin day was a thursday, weekday counts monday as 1
            r.week_day        = 3'((days + 64'd3) % 64'd7 + 64'd1);
        end
        return r;
    endfunction

    task automatic add_row(input logic [63:0] t, input bit typed, input rtc_fields_t want);
        row_time.push_back(t);
        row_typed.push_back(typed);
        row_want.push_back(want);
    endtask

    task automatic cmp(input string name, input logic [6:0] want, input logic [6:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatches++;
        end
    endtask

    // present one time and hold it until the transfer is taken; while idling is on,
    // start drops in some cycles, so gaps land on every phase of a conversion
    task automatic send(input logic [63:0] t, input rtc_fields_t want);
        bit taken;
        time_ns     <= t;
        pending_cal <= want;
        start       <= !(idle_on && $urandom_range(99) < 24);
        do
        begin
            @(posedge clk);
            taken = start && !busy;
            if (!taken)
                start <= !(idle_on && $urandom_range(99) < 24);
        end
        while (!taken);
    endtask

    // result checker and transfer tracker share one block, so a result and a new
    // transfer in the same edge are handled in a fixed order
    always @(posedge clk)
    begin
        rtc_fields_t want;
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("FAIL unix_ns_to_rtc_date_time");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (calendar_due.size() == 0)
                begin
                    $error("result with no transfer outstanding");
                    mismatches++;
                end
                else
                begin
                    want = calendar_due.pop_front();
                    cmp("in_range",        7'(want.in_range),        7'(in_range));
                    cmp("year_of_century", 7'(want.year_of_century), 7'(year_of_century));
                    cmp("month_number",    7'(want.month_number),    7'(month_number));
                    cmp("day_of_month",    7'(want.day_of_month),    7'(day_of_month));
                    cmp("hours",           7'(want.hours),           7'(hours));
                    cmp("minutes",         7'(want.minutes),         7'(minutes));
                    cmp("seconds",         7'(want.seconds),         7'(seconds));
                    cmp("week_day",        7'(want.week_day),        7'(week_day));
                end
            end
            if (start && !busy)
                calendar_due.push_back(pending_cal);
        end
    end

    initial
    begin
        logic [63:0] t;
        logic [63:0] delta;
        int unsigned y;
        int unsigned mo;
        int unsigned d;
        int unsigned pick;

        rst_n       = 1'b0;
        start       = 1'b0;
        time_ns     = '0;
        pending_cal = NO_DATE;
        mismatches  = 0;
        cycles      = 0;
        idle_on     = 1'b1;

        // typed rows: the extremes and the out of range cases
        add_row(64'd0,                       1'b1, NO_DATE);  // the origin itself
        add_row('1,                          1'b1, NO_DATE);  // largest input, year 2554
        add_row({1'b1, 63'd0},               1'b1, NO_DATE);  // top bit alone
        add_row(64'h0000_0000_ffff_ffff,     1'b1, NO_DATE);  // low word only, still 1970
        add_row(64'd946684799_999999999,     1'b1, NO_DATE);  // last ns of 1999
        add_row(64'd946684800_000000000,     1'b1,            // first second of 2000, saturday
                {1'b1, 7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 3'd6});
        add_row(64'd4102444799_999999999,    1'b1,            // last ns of 2099, thursday
                {1'b1, 7'd99, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59, 3'd4});
        add_row(64'd4102444800_000000000,    1'b1, NO_DATE);  // first second of 2100
        // predictor rows: leap days, month turns, truncation of the fraction
        add_row(stamp(2000, 2, 29, 12, 0, 0, 0),             1'b0, NO_DATE);
        add_row(stamp(2000, 3, 1, 0, 0, 0, 0),               1'b0, NO_DATE);
        add_row(stamp(2001, 2, 28, 23, 59, 59, 999999999),   1'b0, NO_DATE);
        add_row(stamp(2001, 3, 1, 0, 0, 0, 0),               1'b0, NO_DATE);
        add_row(stamp(2024, 2, 29, 12, 34, 56, 500000000),   1'b0, NO_DATE);
        add_row(stamp(2038, 1, 19, 3, 14, 7, 999999999),     1'b0, NO_DATE);
        add_row(stamp(2038, 1, 19, 3, 14, 8, 0),             1'b0, NO_DATE);
        add_row(stamp(2050, 7, 4, 9, 30, 15, 999999999),     1'b0, NO_DATE);
        add_row(stamp(2063, 6, 30, 23, 59, 59, 1),           1'b0, NO_DATE);
        add_row(stamp(2077, 11, 30, 0, 0, 0, 0),             1'b0, NO_DATE);
        add_row(stamp(2096, 12, 31, 23, 59, 59, 0),          1'b0, NO_DATE);
        add_row(stamp(2099, 1, 1, 0, 0, 0, 0),               1'b0, NO_DATE);
        add_row(stamp(2030, 4, 15, 13, 0, 0, 0),             1'b0, NO_DATE);
        add_row(stamp(2012, 8, 31, 1, 1, 1, 123456789),      1'b0, NO_DATE);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < row_time.size(); i++)
            send(row_time[i], row_typed[i] ? row_want[i] : to_calendar(row_time[i]));

        // random part, mostly dates inside the accepted century
        for (int unsigned i = 0; i < RANDOM_TIMES; i++)
        begin
            idle_on = !(i >= 250 && i < 400);   // long stretch with start held high
            pick    = $urandom_range(99);
            y       = $urandom_range(YEAR_HI, YEAR_LO);
            mo      = $urandom_range(12, 1);
            d       = $urandom_range(mdays(y, mo), 1);
            if (pick < 50)
                t = stamp(y, mo, d, $urandom_range(23), $urandom_range(59),
                          $urandom_range(59), $urandom_range(999999999));
            else if (pick < 65)
                // first or last day of a month, at the ends of the day
                t = stamp(y, mo, $urandom_range(1) ? 1 : mdays(y, mo),
                          $urandom_range(1) ? 0 : 23, $urandom_range(1) ? 0 : 59,
                          $urandom_range(1) ? 0 : 59, $urandom_range(1) ? 0 : 999999999);
            else if (pick < 75)
            begin
                // a few seconds either side of where the century starts or ends
                t     = stamp($urandom_range(1) ? YEAR_LO : YEAR_HI + 1, 1, 1, 0, 0, 0, 0);
                delta = 64'($urandom_range(32'd3000000000));
                t     = $urandom_range(1) ? t + delta : t - delta - 64'd1;
            end
            else if (pick < 88)
            begin
                // years outside the century, before it or up to the largest input
                y = $urandom_range(1) ? $urandom_range(YEAR_LO - 1, YEAR_ORIGIN)
                                      : $urandom_range(2553, YEAR_HI + 1);
                t = stamp(y, mo, $urandom_range(28, 1), $urandom_range(23),
                          $urandom_range(59), $urandom_range(59), $urandom_range(999999999));
            end
            else
                t = {$urandom, $urandom};
            send(t, to_calendar(t));
        end
        start <= 1'b0;

        // drain: every transfer answered, then a quiet spell for stray results
        while (calendar_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("PASS unix_ns_to_rtc_date_time");
        else
            $display("FAIL unix_ns_to_rtc_date_time");
        $finish;
    end

endmodule

@@ files.f @@
rtl/unixdt_pkg.sv
rtl/unixdt_ctrl.sv
rtl/unixdt_dp.sv
rtl/unix_ns_to_rtc_date_time.sv
rtl/unixdt_chk.sv
dv/tb_unix_ns_to_rtc_date_time.sv
